// ===== rtl/svpwm_pkg.sv =====
// ---------------------------------------------------------------------------
// Servo PWM package
// Shared types, constants and reset values for the four-channel servo PWM.
// ---------------------------------------------------------------------------
package svpwm_pkg;

	localparam int NUM_LANES  = 4;
	localparam int CHANNELS   = 4;
	localparam int PERIOD_TOP = 2000;
	localparam int WIDTH_W    = 11;
	localparam int AMOUNT_W   = 8;
	localparam int REG_IDX_W  = 4;

	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [NUM_LANES-1:0][WIDTH_W-1:0] lane_widths_t;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_STEP_UP   = 2'd1,
		OP_STEP_DOWN = 2'd2,
		OP_SET       = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [1:0]          channel;
		logic [AMOUNT_W-1:0] step_amount;
		width_t              target_value;
	} in_item_t;

	typedef struct packed {
		logic [NUM_LANES-1:0] pin_levels;
		width_t               addressed_width;
	} out_item_t;

	// register map: low limits first, then high limits
	localparam logic [REG_IDX_W-1:0] REG_LOW_BASE  = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_BASE = 4'd4;
	localparam logic [REG_IDX_W-1:0] REG_END       = 4'd8;

	localparam lane_widths_t LOW_RESET   = {11'd50, 11'd80, 11'd80, 11'd130};
	localparam lane_widths_t HIGH_RESET  = {11'd250, 11'd220, 11'd185, 11'd250};
	localparam lane_widths_t WIDTH_RESET = {11'd145, 11'd150, 11'd150, 11'd150};

endpackage

// ===== rtl/svpwm_update.sv =====
// ---------------------------------------------------------------------------
// Servo PWM width update
// Forms the stepped or loaded width of one channel and clamps it to limits.
// ---------------------------------------------------------------------------
module svpwm_update (
	input  svpwm_pkg::op_t                          op,
	input  svpwm_pkg::width_t                       cur_width,
	input  logic [svpwm_pkg::AMOUNT_W-1:0]          step_amount,
	input  svpwm_pkg::width_t                       target_value,
	input  svpwm_pkg::width_t                       low_limit,
	input  svpwm_pkg::width_t                       high_limit,
	output svpwm_pkg::width_t                       new_width
);

	localparam int SUM_W = svpwm_pkg::WIDTH_W + 2;

	logic signed [SUM_W-1:0] raw;
	logic signed [SUM_W-1:0] low_s;
	logic signed [SUM_W-1:0] high_s;

	// form the unclamped value at full precision, signed for step down
	always_comb begin
		case (op)
			svpwm_pkg::OP_STEP_UP:
				raw = $signed({2'b00, cur_width}) + $signed({5'b0, step_amount});
			svpwm_pkg::OP_STEP_DOWN:
				raw = $signed({2'b00, cur_width}) - $signed({5'b0, step_amount});
			default:
				raw = $signed({2'b00, target_value});
		endcase
	end

	assign low_s  = $signed({2'b00, low_limit});
	assign high_s = $signed({2'b00, high_limit});

	// low limit wins over high limit
	always_comb begin
		if (raw < low_s) begin
			new_width = low_limit;
		end else if (raw > high_s) begin
			new_width = high_limit;
		end else begin
			new_width = raw[svpwm_pkg::WIDTH_W-1:0];
		end
	end

endmodule

// ===== rtl/svpwm_phase.sv =====
// ---------------------------------------------------------------------------
// Servo PWM phase
// Advances the phase counter and compares it against every channel width.
// ---------------------------------------------------------------------------
module svpwm_phase (
	input  svpwm_pkg::width_t                       phase,
	input  svpwm_pkg::lane_widths_t                 widths,
	output svpwm_pkg::width_t                       phase_next,
	output logic [svpwm_pkg::NUM_LANES-1:0]         pins_next
);

	localparam logic [svpwm_pkg::WIDTH_W:0] TOP = (svpwm_pkg::WIDTH_W+1)'(svpwm_pkg::PERIOD_TOP);
	localparam logic [svpwm_pkg::WIDTH_W:0] ONE = (svpwm_pkg::WIDTH_W+1)'(1);

	logic [svpwm_pkg::WIDTH_W:0] incr;

	// advance and wrap past the top
	assign incr       = {1'b0, phase} + ONE;
	assign phase_next = (incr > TOP) ? '0 : incr[svpwm_pkg::WIDTH_W-1:0];

	// drive high while the counter is below the width
	always_comb begin
		for (int i = 0; i < svpwm_pkg::NUM_LANES; i++) begin
			pins_next[i] = (i < svpwm_pkg::CHANNELS) && (phase_next < widths[i]);
		end
	end

endmodule

// ===== rtl/four_channel_servo_pwm_unit.sv =====
// The result is registered and valid in the cycle after a request is accepted.
// Throughput: one request per cycle while out_ready is high; the result register frees as it is taken.
// Every request (tick, step, set) runs through a single combinational pass.
// Reset: phase counter 0, pins all high, widths 150/150/150/145,
// limits at their default values, no result pending.
// ---------------------------------------------------------------------------
// Four-channel servo PWM unit
// Phase counter, per-channel pulse widths with clamped updates, result register.
// ---------------------------------------------------------------------------
module four_channel_servo_pwm_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  svpwm_pkg::in_item_t                      in_data,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output svpwm_pkg::out_item_t                     out_data,
	input  logic                                     wr_en,
	input  logic [svpwm_pkg::REG_IDX_W-1:0]          wr_index,
	input  svpwm_pkg::width_t                        wr_data
);

	svpwm_pkg::lane_widths_t             low_q;
	svpwm_pkg::lane_widths_t             high_q;
	svpwm_pkg::lane_widths_t             width_q;
	svpwm_pkg::width_t                   phase_q;
	logic [svpwm_pkg::NUM_LANES-1:0]     pin_q;
	logic                                out_valid_q;
	svpwm_pkg::out_item_t                out_data_q;

	logic                                accept;
	logic                                ch_active;
	logic                                is_tick;
	svpwm_pkg::width_t                   upd_width;
	svpwm_pkg::width_t                   phase_next;
	logic [svpwm_pkg::NUM_LANES-1:0]     pins_next;
	svpwm_pkg::width_t                   addr_width;
	logic [svpwm_pkg::NUM_LANES-1:0]     pins_out;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_tick   = (in_data.op == svpwm_pkg::OP_TICK);
	assign ch_active = (32'(in_data.channel) < svpwm_pkg::CHANNELS);

	svpwm_update u_update (
		.op           (in_data.op),
		.cur_width    (width_q[in_data.channel]),
		.step_amount  (in_data.step_amount),
		.target_value (in_data.target_value),
		.low_limit    (low_q[in_data.channel]),
		.high_limit   (high_q[in_data.channel]),
		.new_width    (upd_width)
	);

	svpwm_phase u_phase (
		.phase      (phase_q),
		.widths     (width_q),
		.phase_next (phase_next),
		.pins_next  (pins_next)
	);

	// select the result fields
	always_comb begin
		if (!ch_active) begin
			addr_width = '0;
		end else if (is_tick) begin
			addr_width = width_q[in_data.channel];
		end else begin
			addr_width = upd_width;
		end
		pins_out = is_tick ? pins_next : pin_q;
	end

	// write limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= svpwm_pkg::LOW_RESET;
			high_q <= svpwm_pkg::HIGH_RESET;
		end else if (wr_en) begin
			if (wr_index < svpwm_pkg::REG_HIGH_BASE) begin
				low_q[wr_index[1:0]] <= wr_data;
			end else if (wr_index < svpwm_pkg::REG_END) begin
				high_q[wr_index[1:0]] <= wr_data;
			end
		end
	end

	// advance phase, pins and the addressed width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pin_q   <= '1;
			width_q <= svpwm_pkg::WIDTH_RESET;
		end else if (accept) begin
			if (is_tick) begin
				phase_q <= phase_next;
				pin_q   <= pins_next;
			end else if (ch_active) begin
				width_q[in_data.channel] <= upd_width;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.pin_levels      <= pins_out;
			out_data_q.addressed_width <= addr_width;
		end
	end

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request produced no result");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while result stalled");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(phase_q) <= svpwm_pkg::PERIOD_TOP)
		else $error("phase counter beyond period top");

	a_tick_keeps_widths: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_tick) |=> $stable(width_q))
		else $error("tick changed a pulse width");
`endif

endmodule
